// ===== hw/rtl/ict_pkg.sv =====
// ----------------------------------------------------------------------------
// ict_pkg
// Shared types and constants for the interval count table.
// ----------------------------------------------------------------------------
`default_nettype none

package ict_pkg;

  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_COUNT_BITS  = 16;
  localparam int VAL_W           = 32;   // Q16.16 positions
  localparam int CMD_W           = 3;
  localparam int STAT_W          = 2;
  localparam int THR_W           = 16;   // cull threshold register
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_FIND = 3'd1,
    CMD_CULL = 3'd2,
    CMD_CLR  = 3'd3,
    CMD_HEAD = 3'd4,
    CMD_TAIL = 3'd5
  } ict_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } ict_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_MLOAD,
    S_MNEXT,
    S_REMOVE,
    S_CULL,
    S_FIND,
    S_READ,
    S_SUMINIT,
    S_SUM
  } ict_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ict_store.sv =====
// ----------------------------------------------------------------------------
// ict_store
// Entry table: start, end and count per entry, one write and one read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ict_store
  import ict_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  localparam int IW = $clog2(MAX_ENTRIES)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [IW-1:0]           wr_addr,
  input  wire logic signed [VAL_W-1:0] wr_start,
  input  wire logic signed [VAL_W-1:0] wr_end,
  input  wire logic [COUNT_BITS-1:0]   wr_hits,
  input  wire logic [IW-1:0]           rd_addr,
  output logic signed [VAL_W-1:0]      rd_start,
  output logic signed [VAL_W-1:0]      rd_end,
  output logic [COUNT_BITS-1:0]        rd_hits
);

  logic signed [VAL_W-1:0] start_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] end_mem   [MAX_ENTRIES];
  logic [COUNT_BITS-1:0]   hit_mem   [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
      hit_mem[wr_addr]   <= wr_hits;
    end
  end

  assign rd_start = start_mem[rd_addr];
  assign rd_end   = end_mem[rd_addr];
  assign rd_hits  = hit_mem[rd_addr];

endmodule

`default_nettype wire

// ===== hw/rtl/interval_count_table_top.sv =====
// ----------------------------------------------------------------------------
// interval_count_table_top
// Sorted interval table with hit counts, driven by a small sequencer.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_tready is low while a command runs and while
// its result waits. Every command ends with a count pass over the table: a
// set-up step, a step per entry and a finishing step. Add scans up to
// occupancy entries, shifts the tail up one entry a cycle, then runs the
// merge walk, where each merge is followed by a removal shift of the entries
// behind it. Find and cull visit one entry per cycle (cull adds a shift per
// removal); a read fetches its entry in a single step before the count pass,
// and a clear empties the table at once. The pace of every command is set by
// the single read and write port of the entry table. Reset needs no clearing
// pass.
`default_nettype none

module interval_count_table_top
  import ict_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  localparam int IW    = $clog2(MAX_ENTRIES),
  localparam int SW    = $clog2(MAX_ENTRIES + 1),
  localparam int TW    = COUNT_BITS + IW,
  localparam int IN_R  = CMD_W + 3 * VAL_W + IW,
  localparam int IN_W  = ((IN_R + 7) / 8) * 8,
  localparam int OUT_R = STAT_W + 2 * VAL_W + COUNT_BITS + IW + SW + TW,
  localparam int OUT_W = ((OUT_R + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // cmd, interval start, interval end, point, entry index
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // status, entry_start, entry_end, entry_hits, entry_position, list_size,
  // total_hits
  output logic [OUT_W-1:0]       out_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int O_S = CMD_W;
  localparam int O_E = O_S + VAL_W;
  localparam int O_P = O_E + VAL_W;
  localparam int O_K = O_P + VAL_W;
  localparam int CMPW = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int RW = COUNT_BITS + 3;

  ict_state_t state_r, state_nxt;

  logic [THR_W-1:0]        thr_r;
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic signed [VAL_W-1:0] s_r, s_nxt, e_r, e_nxt, pt_r, pt_nxt;
  logic [IW-1:0]           k_r, k_nxt;
  logic [SW-1:0]           i_r, i_nxt, j_r, j_nxt, p_r, p_nxt, occ_r, occ_nxt;
  logic                    ret_cull_r, ret_cull_nxt;
  logic signed [VAL_W-1:0] cur_s_r, cur_s_nxt, cur_e_r, cur_e_nxt;
  logic [COUNT_BITS-1:0]   cur_h_r, cur_h_nxt;
  logic [TW-1:0]           sum_r, sum_nxt, total_r, total_nxt;
  logic                    ov_r, ov_nxt;
  logic [STAT_W-1:0]       st_r, st_nxt;
  logic signed [VAL_W-1:0] rs_r, rs_nxt, re_r, re_nxt;
  logic [COUNT_BITS-1:0]   rh_r, rh_nxt;
  logic [IW-1:0]           rp_r, rp_nxt;

  logic                    we;
  logic [IW-1:0]           wa, ra;
  logic signed [VAL_W-1:0] ws, wend;
  logic [COUNT_BITS-1:0]   wh;
  logic signed [VAL_W-1:0] rd_s, rd_e;
  logic [COUNT_BITS-1:0]   rd_h;

  logic          accept;
  logic [SW:0]   i_inc, j_inc;
  logic [SW-1:0] j_dec, k_ext, tail_p;
  logic          i_end, dup, ge, j_gt_p, nxt_ok, rem_more, low_hit, pt_hit, rd_ok;
  logic          ovl, ratio_ok, mrg;
  logic [COUNT_BITS-1:0] h_inc, h_sum, a_c, b_c;
  logic [COUNT_BITS:0]   h_sum_w;
  logic [RW-1:0]         a4, b1, b3;

  ict_store #(.MAX_ENTRIES(MAX_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_store (
    .clk      (clk),
    .wr_en    (we),
    .wr_addr  (wa),
    .wr_start (ws),
    .wr_end   (wend),
    .wr_hits  (wh),
    .rd_addr  (ra),
    .rd_start (rd_s),
    .rd_end   (rd_e),
    .rd_hits  (rd_h)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? '0 : CFG_DW'(thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign accept    = in_tvalid && in_tready;

  // shared compare unit
  assign i_inc    = {1'b0, i_r} + 1'b1;
  assign j_inc    = {1'b0, j_r} + 1'b1;
  assign j_dec    = j_r - 1'b1;
  assign k_ext    = SW'(k_r);
  assign tail_p   = occ_r - 1'b1 - k_ext;
  assign i_end    = i_r >= occ_r;
  assign dup      = (rd_s == s_r) && (rd_e == e_r);
  assign ge       = rd_s >= s_r;
  assign j_gt_p   = j_r > p_r;
  assign nxt_ok   = i_inc < {1'b0, occ_r};
  assign rem_more = j_inc < {1'b0, occ_r};
  assign low_hit  = CMPW'(rd_h) < CMPW'(thr_r);
  assign pt_hit   = (rd_s <= pt_r) && (rd_e >= pt_r);
  assign rd_ok    = k_ext < occ_r;

  assign h_inc    = (&rd_h) ? rd_h : rd_h + 1'b1;
  assign h_sum_w  = {1'b0, cur_h_r} + {1'b0, rd_h};
  assign h_sum    = h_sum_w[COUNT_BITS] ? '1 : h_sum_w[COUNT_BITS-1:0];
  assign a_c      = (cur_h_r < rd_h) ? cur_h_r : rd_h;
  assign b_c      = (cur_h_r < rd_h) ? rd_h : cur_h_r;
  assign a4       = {1'b0, a_c, 2'b00};
  assign b1       = RW'(b_c) + 1'b1;
  assign b3       = b1 + {b1[RW-2:0], 1'b0};
  // 0.25 < a/(b+1) < 0.75 as integer compares
  assign ratio_ok = (a4 > b1) && (a4 < b3);
  assign ovl      = cur_e_r >= rd_s;
  assign mrg      = ovl && ratio_ok;

  always_comb begin
    case (state_r)
      S_SHIFT:  ra = j_dec[IW-1:0];
      S_MNEXT:  ra = i_inc[IW-1:0];
      S_REMOVE: ra = j_inc[IW-1:0];
      S_READ:   ra = (cmd_r == CMD_HEAD) ? k_r : tail_p[IW-1:0];
      default:  ra = i_r[IW-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tdata[CMD_W-1:0])
            CMD_ADD:            state_nxt = S_SCAN;
            CMD_FIND:           state_nxt = S_FIND;
            CMD_CULL:           state_nxt = S_CULL;
            CMD_HEAD, CMD_TAIL: state_nxt = S_READ;
            default:            state_nxt = S_SUMINIT;
          endcase
        end
      end
      S_SCAN: begin
        if (!i_end && dup) begin
          state_nxt = S_SUMINIT;
        end else if (i_end || ge) begin
          state_nxt = (occ_r >= SW'(MAX_ENTRIES)) ? S_SUMINIT : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!j_gt_p) state_nxt = S_MLOAD;
      end
      S_MLOAD: state_nxt = S_MNEXT;
      S_MNEXT: begin
        if (!nxt_ok) state_nxt = S_SUMINIT;
        else if (mrg) state_nxt = S_REMOVE;
      end
      S_REMOVE: begin
        if (!rem_more) state_nxt = ret_cull_r ? S_CULL : S_MNEXT;
      end
      S_CULL: begin
        if (i_end) state_nxt = S_SUMINIT;
        else if (low_hit) state_nxt = S_REMOVE;
      end
      S_FIND: begin
        if (i_end || pt_hit) state_nxt = S_SUMINIT;
      end
      S_READ:    state_nxt = S_SUMINIT;
      S_SUMINIT: state_nxt = S_SUM;
      S_SUM: begin
        if (i_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt      = cmd_r;
    s_nxt        = s_r;
    e_nxt        = e_r;
    pt_nxt       = pt_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    occ_nxt      = occ_r;
    ret_cull_nxt = ret_cull_r;
    cur_s_nxt    = cur_s_r;
    cur_e_nxt    = cur_e_r;
    cur_h_nxt    = cur_h_r;
    sum_nxt      = sum_r;
    total_nxt    = total_r;
    ov_nxt       = ov_r;
    st_nxt       = st_r;
    rs_nxt       = rs_r;
    re_nxt       = re_r;
    rh_nxt       = rh_r;
    rp_nxt       = rp_r;
    we           = 1'b0;
    wa           = i_r[IW-1:0];
    ws           = rd_s;
    wend         = rd_e;
    wh           = rd_h;
    case (state_r)
      S_IDLE: begin
        if (ov_r && out_tready) ov_nxt = 1'b0;
        if (accept) begin
          cmd_nxt = in_tdata[CMD_W-1:0];
          s_nxt   = in_tdata[O_E-1:O_S];
          e_nxt   = in_tdata[O_P-1:O_E];
          pt_nxt  = in_tdata[O_K-1:O_P];
          k_nxt   = in_tdata[O_K+IW-1:O_K];
          i_nxt   = '0;
          st_nxt  = ST_OK;
          rs_nxt  = '0;
          re_nxt  = '0;
          rh_nxt  = '0;
          rp_nxt  = '0;
          ret_cull_nxt = (in_tdata[CMD_W-1:0] == CMD_CULL);
          if (in_tdata[CMD_W-1:0] == CMD_CLR) occ_nxt = '0;
        end
      end
      S_SCAN: begin
        if (!i_end && dup) begin
          we = 1'b1;
          wh = h_inc;
        end else if (i_end || ge) begin
          p_nxt = i_r;
          j_nxt = occ_r;
          if (occ_r >= SW'(MAX_ENTRIES)) st_nxt = ST_FULL;
        end else begin
          i_nxt = i_inc[SW-1:0];
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        wa = j_r[IW-1:0];
        if (j_gt_p) begin
          j_nxt = j_dec;
        end else begin
          wa      = p_r[IW-1:0];
          ws      = s_r;
          wend    = e_r;
          wh      = COUNT_BITS'(1);
          occ_nxt = occ_r + 1'b1;
          i_nxt   = '0;
        end
      end
      S_MLOAD: begin
        cur_s_nxt = rd_s;
        cur_e_nxt = rd_e;
        cur_h_nxt = rd_h;
      end
      S_MNEXT: begin
        if (nxt_ok) begin
          if (mrg) begin
            // fold successor into entry i, then close the gap
            cur_h_nxt = h_sum;
            if (rd_e > cur_e_r) cur_e_nxt = rd_e;
            we    = 1'b1;
            wa    = i_r[IW-1:0];
            ws    = cur_s_r;
            wend  = (rd_e > cur_e_r) ? rd_e : cur_e_r;
            wh    = h_sum;
            j_nxt = i_inc[SW-1:0];
          end else begin
            i_nxt     = i_inc[SW-1:0];
            cur_s_nxt = rd_s;
            cur_e_nxt = rd_e;
            cur_h_nxt = rd_h;
          end
        end
      end
      S_REMOVE: begin
        if (rem_more) begin
          we    = 1'b1;
          wa    = j_r[IW-1:0];
          j_nxt = j_inc[SW-1:0];
        end else begin
          occ_nxt = occ_r - 1'b1;
        end
      end
      S_CULL: begin
        if (!i_end) begin
          if (low_hit) j_nxt = i_r;
          else i_nxt = i_inc[SW-1:0];
        end
      end
      S_FIND: begin
        if (i_end) begin
          st_nxt = ST_MISS;
        end else if (pt_hit) begin
          rs_nxt = rd_s;
          re_nxt = rd_e;
          rh_nxt = rd_h;
          rp_nxt = i_r[IW-1:0];
        end else begin
          i_nxt = i_inc[SW-1:0];
        end
      end
      S_READ: begin
        if (rd_ok) begin
          rs_nxt = rd_s;
          re_nxt = rd_e;
          rh_nxt = rd_h;
          rp_nxt = ra;
        end else begin
          st_nxt = ST_MISS;
        end
      end
      S_SUMINIT: begin
        i_nxt   = '0;
        sum_nxt = '0;
      end
      S_SUM: begin
        if (i_end) begin
          total_nxt = sum_r;
          ov_nxt    = 1'b1;
        end else begin
          sum_nxt = sum_r + TW'(rd_h);
          i_nxt   = i_inc[SW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    pt_r       <= pt_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    ret_cull_r <= ret_cull_nxt;
    cur_s_r    <= cur_s_nxt;
    cur_e_r    <= cur_e_nxt;
    cur_h_r    <= cur_h_nxt;
    sum_r      <= sum_nxt;
    st_r       <= st_nxt;
    rs_r       <= rs_nxt;
    re_r       <= re_nxt;
    rh_r       <= rh_nxt;
    rp_r       <= rp_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'({total_r, occ_r, rp_r, rh_r, re_r, rs_r, st_r});

endmodule

`default_nettype wire

// ===== hw/rtl/ict_checker.sv =====
// ----------------------------------------------------------------------------
// ict_checker
// Port-level checks on the interval count table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ict_checker
  import ict_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int OUT_W       = 120
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready
);

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int SW  = $clog2(MAX_ENTRIES + 1);
  localparam int O_Z = STAT_W + 2 * VAL_W + COUNT_BITS + IW;

  logic [STAT_W-1:0] st;
  logic [O_Z-STAT_W-1:0] ent;
  logic [SW-1:0] size;

  assign st   = out_tdata[STAT_W-1:0];
  assign ent  = out_tdata[O_Z-1:STAT_W];
  assign size = out_tdata[O_Z+SW-1:O_Z];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("item taken while a result waits");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result shown in the cycle after an item");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> size <= SW'(MAX_ENTRIES))
    else $error("list size beyond capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> ent == '0)
    else $error("entry fields set with non-ok status");

endmodule

bind interval_count_table_top ict_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .COUNT_BITS  (COUNT_BITS),
  .OUT_W       (OUT_W)
) u_ict_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== tb/interval_count_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// interval_count_table_top_tb
// Self-checking bench for the interval count table.
// Directed items cover extreme positions, duplicates, merges, reversed
// intervals, reads out of range, a full table and the spare command codes.
// Random phases follow, each with its own cull threshold. A scoreboard class
// keeps a copy of the table and checks every result item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_count_table_top_tb;
  import ict_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE    = 32;
  localparam int IN_W  = 104;
  localparam int OUT_W = 120;
  localparam int CNT_SAT = 65535;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam logic [CFG_AW-1:0] REG_CULL_THR = 3'd0;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [15:0]        hits;
    logic [4:0]         pos;
    logic [5:0]         size;
    logic [20:0]        total;
  } ict_result_t;

  class ict_scoreboard;
    logic signed [31:0] lo_tab[NE];
    logic signed [31:0] hi_tab[NE];
    int unsigned        cnt_tab[NE];
    int                 occ;
    int unsigned        thr;
    ict_result_t        pending_q[$];
    int                 errors;

    function void init();
      occ = 0;
      thr = 0;
      errors = 0;
    endfunction

    function int unsigned sat_sum(int unsigned a, int unsigned b);
      return (a + b > CNT_SAT) ? CNT_SAT : a + b;
    endfunction

    function void drop_entry(int p);
      for (int i = p; i < occ - 1; i++) begin
        lo_tab[i]  = lo_tab[i+1];
        hi_tab[i]  = hi_tab[i+1];
        cnt_tab[i] = cnt_tab[i+1];
      end
      occ--;
    endfunction

    function void merge_walk();
      int i;
      int unsigned a, b;
      i = 0;
      while (i < occ) begin
        if (i + 1 < occ && hi_tab[i] >= lo_tab[i+1]) begin
          a = (cnt_tab[i] < cnt_tab[i+1]) ? cnt_tab[i] : cnt_tab[i+1];
          b = (cnt_tab[i] < cnt_tab[i+1]) ? cnt_tab[i+1] : cnt_tab[i];
          if (4 * a > b + 1 && 4 * a < 3 * (b + 1)) begin
            cnt_tab[i] = sat_sum(cnt_tab[i], cnt_tab[i+1]);
            if (hi_tab[i+1] > hi_tab[i]) hi_tab[i] = hi_tab[i+1];
            drop_entry(i + 1);
            continue;
          end
        end
        i++;
      end
    endfunction

    function void take_entry(ref ict_result_t r, input int p);
      r.status = ST_OK;
      r.lo     = lo_tab[p];
      r.hi     = hi_tab[p];
      r.hits   = 16'(cnt_tab[p]);
      r.pos    = 5'(p);
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_item(logic [CMD_W-1:0] op, logic signed [31:0] s,
                            logic signed [31:0] e, logic signed [31:0] x,
                            logic [4:0] k);
      ict_result_t r;
      int p, i;
      bit dup;
      int unsigned sum;
      r = '{default: '0};
      dup = 0;
      case (op)
        CMD_ADD: begin
          p = occ;
          for (i = 0; i < occ; i++) begin
            if (lo_tab[i] == s && hi_tab[i] == e) begin
              cnt_tab[i] = sat_sum(cnt_tab[i], 1);
              dup = 1;
              break;
            end
            if (lo_tab[i] >= s) begin
              p = i;
              break;
            end
          end
          if (!dup) begin
            if (occ >= NE) begin
              r.status = ST_FULL;
            end else begin
              for (i = occ; i > p; i--) begin
                lo_tab[i]  = lo_tab[i-1];
                hi_tab[i]  = hi_tab[i-1];
                cnt_tab[i] = cnt_tab[i-1];
              end
              lo_tab[p] = s;
              hi_tab[p] = e;
              cnt_tab[p] = 1;
              occ++;
              merge_walk();
            end
          end
        end
        CMD_FIND: begin
          r.status = ST_MISS;
          for (i = 0; i < occ; i++) begin
            if (lo_tab[i] <= x && hi_tab[i] >= x) begin
              take_entry(r, i);
              break;
            end
          end
        end
        CMD_CULL: begin
          i = 0;
          while (i < occ) begin
            if (cnt_tab[i] < thr) drop_entry(i);
            else i++;
          end
        end
        CMD_CLR: occ = 0;
        CMD_HEAD, CMD_TAIL: begin
          if (k < occ) take_entry(r, (op == CMD_HEAD) ? k : occ - 1 - k);
          else r.status = ST_MISS;
        end
        default: ;
      endcase
      sum = 0;
      for (i = 0; i < occ; i++) sum += cnt_tab[i];
      r.size  = 6'(occ);
      r.total = 21'(sum);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      ict_result_t got, want;
      got.status = d[1:0];
      got.lo     = d[33:2];
      got.hi     = d[65:34];
      got.hits   = d[81:66];
      got.pos    = d[86:82];
      got.size   = d[92:87];
      got.total  = d[113:93];
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %h", d);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status || got.lo !== want.lo || got.hi !== want.hi ||
          got.hits !== want.hits || got.pos !== want.pos ||
          got.size !== want.size || got.total !== want.total) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp st=%0d lo=%h hi=%h hits=%0d pos=%0d size=%0d tot=%0d",
                   want.status, want.lo, want.hi, want.hits, want.pos, want.size,
                   want.total);
          $display("          got st=%0d lo=%h hi=%h hits=%0d pos=%0d size=%0d tot=%0d",
                   got.status, got.lo, got.hi, got.hits, got.pos, got.size,
                   got.total);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic [IN_W-1:0]  in_tdata;   // cmd, interval start, interval end, point, entry index
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;  // status, entry_start, entry_end, entry_hits,
                                // entry_position, list_size, total_hits
  logic             out_tvalid;
  logic             out_tready;
  logic             cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic             cfg_pready;

  ict_scoreboard sb;
  bit quiet;      // no idling on either side
  bit long_hold;  // asks the receiver for one long hold-off
  int sent;

  interval_count_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: checks items and stalls in bursts.
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (long_hold) begin
        long_hold = 0;
        stall = 500;
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] op, logic [31:0] s, logic [31:0] e,
                           logic [31:0] x, logic [4:0] k);
    in_tdata  <= {k, x, e, s, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, s, e, x, k);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Let the table go idle, then write the cull threshold.
  task automatic set_threshold(int unsigned v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= REG_CULL_THR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.thr = v;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Positions mostly on a coarse grid so that duplicates and overlaps are common.
  function automatic logic [31:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return ($urandom_range(0, 40) - 20) * 32'sh10000 + $urandom_range(0, 3) * 32'sh4000;
  endfunction

  task automatic random_item();
    int r;
    logic [31:0] s, e;
    r = $urandom_range(0, 99);
    s = pick_pos();
    e = ($urandom_range(0, 15) == 0) ? pick_pos()
                                     : s + $urandom_range(0, 5) * 32'sh10000;
    if (r < 55)      send_item(CMD_ADD, s, e, $urandom, 5'($urandom));
    else if (r < 70) send_item(CMD_FIND, $urandom, $urandom, pick_pos(), 5'($urandom));
    else if (r < 75) send_item(CMD_CULL, $urandom, $urandom, $urandom, 5'($urandom));
    else if (r < 77) send_item(CMD_CLR, $urandom, $urandom, $urandom, 5'($urandom));
    else if (r < 87) send_item(CMD_HEAD, $urandom, $urandom, $urandom, 5'($urandom));
    else if (r < 97) send_item(CMD_TAIL, $urandom, $urandom, $urandom, 5'($urandom));
    else             send_item($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                               $urandom, $urandom, $urandom, 5'($urandom));
  endtask

  initial begin
    int unsigned thr_set[5];
    sb = new();
    sb.init();
    quiet = 0;
    long_hold = 0;
    sent = 0;
    rst_n = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    send_item(CMD_FIND, 0, 0, 0, 0);
    send_item(CMD_HEAD, 0, 0, 0, 0);
    send_item(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
    send_item(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 0, 0);   // duplicate
    send_item(CMD_ADD, 32'h0005_0000, 32'h0001_0000, 0, 0);   // reversed
    send_item(CMD_ADD, 32'h0010_0000, 32'h0012_0000, 0, 0);
    send_item(CMD_ADD, 32'h0011_0000, 32'h0014_0000, 0, 0);   // overlap, merges
    send_item(CMD_FIND, 0, 0, 32'h7fff_ffff, 0);
    send_item(CMD_FIND, 0, 0, 32'h8000_0000, 0);
    send_item(CMD_FIND, 0, 0, 32'h0013_8000, 0);
    send_item(CMD_HEAD, 0, 0, 0, 5'd1);
    send_item(CMD_TAIL, 0, 0, 0, 5'd0);
    send_item(CMD_TAIL, 0, 0, 0, 5'd31);
    send_item(CMD_HEAD, 0, 0, 0, 5'd31);
    send_item(CMD_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 5'd31);
    send_item(CMD_SPARE_B, 0, 0, 0, 0);
    send_item(CMD_CULL, 0, 0, 0, 0);
    send_item(CMD_CLR, 0, 0, 0, 0);
    set_threshold(2);
    send_item(CMD_ADD, 32'h0001_0000, 32'h0002_0000, 0, 0);
    send_item(CMD_ADD, 32'h0001_0000, 32'h0002_0000, 0, 0);
    send_item(CMD_ADD, 32'h0004_0000, 32'h0005_0000, 0, 0);
    send_item(CMD_CULL, 0, 0, 0, 0);
    send_item(CMD_HEAD, 0, 0, 0, 0);

    thr_set = '{0, 65535, 1, 3, $urandom_range(4, 65534)};
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(thr_set[ph]);
      if (ph == 1) begin
        // fill the table with disjoint intervals, then overflow it
        send_item(CMD_CLR, 0, 0, 0, 0);
        for (int i = 0; i < 35; i++)
          send_item(CMD_ADD, (i - 17) * 32'sh100000, (i - 17) * 32'sh100000 + 1, 0, 0);
        send_item(CMD_ADD, (3 - 17) * 32'sh100000, (3 - 17) * 32'sh100000 + 1, 0, 0);
        send_item(CMD_TAIL, 0, 0, 0, 5'd31);
        send_item(CMD_HEAD, 0, 0, 0, 5'd31);
        long_hold = 1;
      end
      for (int n = 0; n < 160; n++) begin
        if (ph == 4 && n == 60) quiet = 1;
        random_item();
      end
    end
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
